// ===== rtl/rrws_pkg.sv =====
// ----------------------------------------------------------------------------
// rrws_pkg: shared definitions for the round-robin wait scheduler
// Slot table sizing, reset constants, opcode codes and the stack pointer
// memory request type.
// ----------------------------------------------------------------------------
package rrws_pkg;

  localparam int SLOT_COUNT = 8;
  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  localparam logic [15:0] DEFAULT_SP = 16'hFF00;
  localparam logic [3:0]  WAIT_NONE  = 4'hF;

  // Opcodes of an input word
  localparam logic [2:0] OP_TICK      = 3'd0;
  localparam logic [2:0] OP_LAUNCH    = 3'd1;
  localparam logic [2:0] OP_KILL      = 3'd2;
  localparam logic [2:0] OP_STALL     = 3'd3;
  localparam logic [2:0] OP_TERMINATE = 3'd4;

  // Configuration register index
  localparam logic REG_INIT_SP = 1'b0;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    logic [15:0]       wdata;
    logic [SLOT_W-1:0] raddr;
  } sp_req_t;

endpackage

// ===== rtl/rrws_sp_mem.sv =====
// ----------------------------------------------------------------------------
// rrws_sp_mem: saved stack pointer store
// One write and one registered read per cycle; entries never written since
// reset read as the default stack pointer.
// ----------------------------------------------------------------------------
module rrws_sp_mem
  import rrws_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  sp_req_t     req,
  output logic [15:0] rdata
);

  logic [15:0]           mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] vld_r;
  logic [15:0]           rdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (req.we) begin
      vld_r[req.waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    // Fall back to the default for entries still untouched
    rdata_r <= vld_r[req.raddr] ? mem[req.raddr] : DEFAULT_SP;
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/round_robin_wait_scheduler.sv =====
// ----------------------------------------------------------------------------
// round_robin_wait_scheduler: process slot table with round-robin pick
// Keeps per-slot active flag, saved stack pointer and waited-on slot, and
// serves tick, launch, kill, stall and terminate commands one at a time.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on the in_ stream; each yields exactly one result word
//   on the out_ stream. The APB-style cfg_ port holds the initial stack
//   pointer at byte address 0; write it only while the block is idle.
//   Steps from accept to out_tvalid (each path ends in ST_FINISH):
//     tick       - the scan walks the slot table one entry at a time,
//                  visiting up to SLOT_COUNT = 8 slots, reading the wait
//                  table (ST_TICK_RD) and then testing the slot (ST_TICK_CHK);
//                  a pick also reads the saved stack pointer (ST_TICK_SP).
//     launch     - searches up to SLOT_COUNT slots from slot 0 in ST_LAUNCH.
//     other ops  - go straight to ST_FINISH.
//   in_tready is low from accept until the result is loaded into the output
//   register, so one word is in flight; the next accept can come at the
//   earliest in the cycle that out_tvalid rises. A result waiting on a stalled
//   receiver does not block the next accept; if that next result finishes
//   while the output register is still full, the block holds it until
//   out_tready frees the register.
//   Reset clears all slots to inactive and not waiting, forgets the current
//   slot, sets the initial stack pointer to 0xff00 and every saved stack
//   pointer reads as 0xff00 until written.
// ----------------------------------------------------------------------------
module round_robin_wait_scheduler
  import rrws_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: opcode[2:0], save_segment[18:3], save_sp[34:19],
  //           target_id[38:35], zero pad[39]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,
  // out_tdata: next_segment[15:0], next_stack_pointer[31:16],
  //            assigned_slot[34:32], table_full[35], zero pad[39:36]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK_RD,
    ST_TICK_CHK,
    ST_TICK_SP,
    ST_LAUNCH,
    ST_FINISH
  } state_t;

  // Unpack the input word
  logic [2:0]        in_opcode;
  logic [15:0]       in_save_segment;
  logic [15:0]       in_save_sp;
  logic signed [3:0] in_target_id;

  assign in_opcode       = in_tdata[2:0];
  assign in_save_segment = in_tdata[18:3];
  assign in_save_sp      = in_tdata[34:19];
  assign in_target_id    = in_tdata[38:35];

  state_t                state_r, state_nxt;
  logic [SLOT_COUNT-1:0] active_r, active_nxt;
  logic [3:0]            wait_r [SLOT_COUNT];
  logic [3:0]            wait_nxt [SLOT_COUNT];
  logic                  cur_vld_r, cur_vld_nxt;
  logic [SLOT_W-1:0]     cur_r, cur_nxt;
  logic [15:0]           init_sp_r, init_sp_nxt;
  logic [SLOT_W-1:0]     s_r, s_nxt;       // slot under scan
  logic [SLOT_W-1:0]     cnt_r, cnt_nxt;   // slots visited so far
  logic [3:0]            w_r, w_nxt;       // wait target of the scanned slot
  logic [15:0]           seg_r, seg_nxt;   // latched input segment
  logic [15:0]           sp_r, sp_nxt;     // latched input stack pointer
  logic [15:0]           res_seg_r, res_seg_nxt;
  logic [15:0]           res_sp_r, res_sp_nxt;
  logic [2:0]            res_slot_r, res_slot_nxt;
  logic                  res_full_r, res_full_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [39:0]           out_data_r, out_data_nxt;

  sp_req_t               sp_req;
  logic [15:0]           sp_rdata;

  rrws_sp_mem u_sp_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sp_req),
    .rdata (sp_rdata)
  );

  // Configuration port
  logic cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_INIT_SP) ? {16'h0000, init_sp_r} : 32'h0;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Decode helpers
  logic [3:0]        seg_page;
  logic              save_ok;
  logic [SLOT_W-1:0] save_slot;
  logic              kill_ok;
  logic [SLOT_W-1:0] next_s;
  logic              w_in_table;
  logic [SLOT_W-1:0] w_idx;
  logic              w_done;
  logic              wake;
  logic              s_active;
  logic              free_slot;

  assign seg_page  = in_save_segment[15:12];
  assign save_ok   = (seg_page >= 4'd2) &&
                     ((5'(seg_page) - 5'd2) < 5'(SLOT_COUNT));
  assign save_slot = SLOT_W'(seg_page - 4'd2);
  assign kill_ok   = !in_target_id[3] && ({1'b0, in_target_id[3:0]} < 5'(SLOT_COUNT));
  assign next_s    = (s_r == SLOT_W'(SLOT_COUNT - 1)) ? '0 : s_r + 1'b1;

  // Wake test for the scanned slot: target finished, or target off the table
  assign w_in_table = !w_r[3] && ({1'b0, w_r} < 5'(SLOT_COUNT));
  assign w_idx      = SLOT_W'(w_r);
  assign w_done     = w_in_table ? (!active_r[w_idx] && (wait_r[w_idx] == WAIT_NONE))
                                 : 1'b1;
  assign wake       = (w_r != WAIT_NONE) && w_done;
  assign s_active   = active_r[s_r] | wake;
  assign free_slot  = !active_r[s_r] && (wait_r[s_r] == WAIT_NONE);

  always_comb begin
    state_nxt     = state_r;
    active_nxt    = active_r;
    wait_nxt      = wait_r;
    cur_vld_nxt   = cur_vld_r;
    cur_nxt       = cur_r;
    init_sp_nxt   = init_sp_r;
    s_nxt         = s_r;
    cnt_nxt       = cnt_r;
    w_nxt         = w_r;
    seg_nxt       = seg_r;
    sp_nxt        = sp_r;
    res_seg_nxt   = res_seg_r;
    res_sp_nxt    = res_sp_r;
    res_slot_nxt  = res_slot_r;
    res_full_nxt  = res_full_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    sp_req.we     = 1'b0;
    sp_req.waddr  = save_slot;
    sp_req.wdata  = in_save_sp;
    sp_req.raddr  = s_r;

    if (cfg_wr && (cfg_paddr[2] == REG_INIT_SP)) begin
      init_sp_nxt = cfg_pwdata[15:0];
    end

    // Drop the result once taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          seg_nxt      = in_save_segment;
          sp_nxt       = in_save_sp;
          res_seg_nxt  = '0;
          res_sp_nxt   = '0;
          res_slot_nxt = '0;
          res_full_nxt = 1'b0;
          state_nxt    = ST_FINISH;
          case (in_opcode)
            OP_TICK: begin
              // Save the interrupted stack pointer if its segment maps to a slot, then start the scan
              sp_req.we = save_ok;
              s_nxt     = cur_vld_r ? ((cur_r == SLOT_W'(SLOT_COUNT - 1)) ? '0
                                                                          : cur_r + 1'b1)
                                    : '0;
              cnt_nxt   = '0;
              state_nxt = ST_TICK_RD;
            end
            OP_LAUNCH: begin
              s_nxt     = '0;
              state_nxt = ST_LAUNCH;
            end
            OP_KILL: begin
              if (kill_ok) begin
                active_nxt[SLOT_W'(in_target_id[3:0])] = 1'b0;
              end
            end
            OP_STALL: begin
              wait_nxt[0]   = in_target_id[3:0];
              active_nxt[0] = 1'b0;
            end
            OP_TERMINATE: begin
              if (cur_vld_r) begin
                active_nxt[cur_r] = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_TICK_RD: begin
        w_nxt     = wait_r[s_r];
        state_nxt = ST_TICK_CHK;
      end

      ST_TICK_CHK: begin
        if (wake) begin
          active_nxt[s_r] = 1'b1;
          wait_nxt[s_r]   = WAIT_NONE;
        end
        if (s_active) begin
          // Pick this slot; its stack pointer arrives next cycle
          cur_vld_nxt = 1'b1;
          cur_nxt     = s_r;
          res_seg_nxt = {4'(5'(s_r) + 5'd2), 12'h000};
          state_nxt   = ST_TICK_SP;
        end else if (cnt_r == SLOT_W'(SLOT_COUNT - 1)) begin
          // Nothing runnable: echo the interrupted context
          res_seg_nxt = seg_r;
          res_sp_nxt  = sp_r;
          state_nxt   = ST_FINISH;
        end else begin
          s_nxt     = next_s;
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = ST_TICK_RD;
        end
      end

      ST_TICK_SP: begin
        res_sp_nxt = sp_rdata;
        state_nxt  = ST_FINISH;
      end

      ST_LAUNCH: begin
        if (free_slot) begin
          sp_req.we       = 1'b1;
          sp_req.waddr    = s_r;
          sp_req.wdata    = init_sp_r;
          active_nxt[s_r] = 1'b1;
          cur_vld_nxt     = 1'b1;
          cur_nxt         = s_r;
          res_slot_nxt    = 3'(s_r);
          state_nxt       = ST_FINISH;
        end else if (s_r == SLOT_W'(SLOT_COUNT - 1)) begin
          res_full_nxt = 1'b1;
          state_nxt    = ST_FINISH;
        end else begin
          s_nxt = s_r + 1'b1;
        end
      end

      ST_FINISH: begin
        // Hold until the output register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {4'h0, res_full_r, res_slot_r, res_sp_r, res_seg_r};
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      active_r    <= '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        wait_r[i] <= WAIT_NONE;
      end
      cur_vld_r   <= 1'b0;
      cur_r       <= '0;
      init_sp_r   <= DEFAULT_SP;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      wait_r      <= wait_nxt;
      cur_vld_r   <= cur_vld_nxt;
      cur_r       <= cur_nxt;
      init_sp_r   <= init_sp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r        <= s_nxt;
    cnt_r      <= cnt_nxt;
    w_r        <= w_nxt;
    seg_r      <= seg_nxt;
    sp_r       <= sp_nxt;
    res_seg_r  <= res_seg_nxt;
    res_sp_r   <= res_sp_nxt;
    res_slot_r <= res_slot_nxt;
    res_full_r <= res_full_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
